@@ hw/rtl/hwb_pkg.sv @@
// hwb_pkg: shared types and codes for the host window bridge
// payload structs for the host and result channels, request and mode codes
// no dependencies
package hwb_pkg;

    localparam int OFFSET_W = 24;
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 16;

    localparam logic [OFFSET_W-1:0] STATUS_OFFSET_DEF = 24'h0F_0000;
    localparam logic [OFFSET_W-1:0] INDEX_OFFSET_DEF  = 24'h02_0000;

    // host access kinds
    localparam logic [1:0] KIND_HOST_READ  = 2'd0;
    localparam logic [1:0] KIND_HOST_WRITE = 2'd1;
    localparam logic [1:0] KIND_MODE_WRITE = 2'd2;

    // transfer modes
    localparam logic [1:0] MODE_OTHER = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // endpoint request codes
    localparam logic [2:0] REQ_NONE      = 3'd0;
    localparam logic [2:0] REQ_READ      = 3'd1;
    localparam logic [2:0] REQ_WRITE     = 3'd2;
    localparam logic [2:0] REQ_CFG_READ  = 3'd3;
    localparam logic [2:0] REQ_CFG_WRITE = 3'd4;

    localparam int READY_BIT = 7;
    localparam logic [WORD_W-1:0] ADDR_STEP = 32'd4;
    localparam logic [WORD_W-1:0] ALL_ONES  = '1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [OFFSET_W-1:0] offset;
        logic [WORD_W-1:0]   wdata;
        logic [1:0]          xfer_mode;
        logic                ep_ack;
        logic [WORD_W-1:0]   ep_rdata;
        logic                cfg_ack;
        logic [7:0]          cfg_rdata;
    } host_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  rdata;
        logic [2:0]         req_kind;
        logic [WORD_W-1:0]  req_addr;
        logic [INDEX_W-1:0] req_index;
        logic [WORD_W-1:0]  req_wdata;
    } res_item_t;

endpackage

@@ hw/rtl/hwb_in_reg.sv @@
// hwb_in_reg: input register of the host window bridge
// depends on hwb_pkg for the host item type
module hwb_in_reg
    import hwb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    output logic       ready,
    input  host_item_t item,
    input  logic       take,
    output logic       stage_valid,
    output host_item_t stage_item
);

    logic       valid_reg;
    logic       valid_next;
    host_item_t item_reg;

    assign ready       = !valid_reg || take;
    assign valid_next  = ready ? valid : valid_reg;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload loads on every accepted transaction
    always_ff @(posedge clk)
    begin
        if (valid && ready)
        begin
            item_reg <= item;
        end
    end

endmodule

@@ hw/rtl/hwb_core.sv @@
// hwb_core: bridge state and per-access decode
// depends on hwb_pkg for item types, access kinds and request codes
module hwb_core
    import hwb_pkg::*;
#(
    parameter logic [OFFSET_W-1:0] STATUS_OFFSET = STATUS_OFFSET_DEF,
    parameter logic [OFFSET_W-1:0] INDEX_OFFSET  = INDEX_OFFSET_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  host_item_t item,
    output res_item_t  result
);

    logic [1:0]          mode_reg,        mode_next;
    logic [WORD_W-1:0]   cur_address_reg, cur_address_next;
    logic                addr_valid_reg,  addr_valid_next;
    logic [WORD_W-1:0]   prefetch_reg,    prefetch_next;
    logic                pf_valid_reg,    pf_valid_next;
    logic [STATUS_W-1:0] status_reg,      status_next;
    logic [INDEX_W-1:0]  cfg_index_reg,   cfg_index_next;
    logic                idx_valid_reg,   idx_valid_next;

    logic                is_status;
    logic                is_index;
    logic [WORD_W-1:0]   addr_inc;
    logic [INDEX_W-1:0]  new_index;

    assign is_status = (item.offset == STATUS_OFFSET);
    assign is_index  = (item.offset == INDEX_OFFSET);
    assign addr_inc  = cur_address_reg + ADDR_STEP;
    assign new_index = {item.wdata[7], item.wdata[3:0]};

    always_comb
    begin
        mode_next        = mode_reg;
        cur_address_next = cur_address_reg;
        addr_valid_next  = addr_valid_reg;
        prefetch_next    = prefetch_reg;
        pf_valid_next    = pf_valid_reg;
        status_next      = status_reg;
        cfg_index_next   = cfg_index_reg;
        idx_valid_next   = idx_valid_reg;
        result           = '0;

        case (item.kind)
            KIND_HOST_READ:
            begin
                result.rdata = ALL_ONES;
                if (is_status)
                begin
                    result.rdata = {{(WORD_W-STATUS_W){1'b0}}, status_reg};
                end
                else if (idx_valid_reg)
                begin
                    result.req_kind  = REQ_CFG_READ;
                    result.req_index = cfg_index_reg;
                    if (item.cfg_ack)
                    begin
                        result.rdata = {{(WORD_W-8){1'b0}}, item.cfg_rdata};
                    end
                    idx_valid_next = 1'b0;
                end
                else if (addr_valid_reg && mode_reg == MODE_READ)
                begin
                    if (pf_valid_reg)
                    begin
                        result.rdata     = prefetch_reg;
                        pf_valid_next    = 1'b0;
                        cur_address_next = addr_inc;
                    end
                    else
                    begin
                        result.req_kind = REQ_READ;
                        result.req_addr = cur_address_reg;
                        if (item.ep_ack)
                        begin
                            result.rdata     = item.ep_rdata;
                            cur_address_next = addr_inc;
                        end
                    end
                end
            end
            KIND_HOST_WRITE:
            begin
                if (is_status)
                begin
                    status_next            = item.wdata[STATUS_W-1:0];
                    status_next[READY_BIT] = 1'b0;
                    addr_valid_next        = 1'b0;
                    pf_valid_next          = 1'b0;
                    idx_valid_next         = 1'b0;
                end
                else if (is_index)
                begin
                    cfg_index_next  = new_index;
                    idx_valid_next  = (new_index != '0);
                    addr_valid_next = 1'b0;
                    pf_valid_next   = 1'b0;
                end
                else if (idx_valid_reg)
                begin
                    result.req_kind  = REQ_CFG_WRITE;
                    result.req_index = cfg_index_reg;
                    result.req_wdata = {{(WORD_W-8){1'b0}}, item.wdata[7:0]};
                    idx_valid_next   = 1'b0;
                end
                else if (!addr_valid_reg)
                begin
                    // first data write latches the 24-bit start address
                    cur_address_next = {{(WORD_W-OFFSET_W){1'b0}}, item.wdata[OFFSET_W-1:0]};
                    addr_valid_next  = 1'b1;
                    pf_valid_next    = 1'b0;
                    if (mode_reg == MODE_READ)
                    begin
                        result.req_kind = REQ_READ;
                        result.req_addr = cur_address_next;
                        if (item.ep_ack)
                        begin
                            prefetch_next          = item.ep_rdata;
                            pf_valid_next          = 1'b1;
                            status_next[READY_BIT] = 1'b1;
                        end
                    end
                end
                else if (mode_reg == MODE_WRITE)
                begin
                    result.req_kind  = REQ_WRITE;
                    result.req_addr  = cur_address_reg;
                    result.req_wdata = item.wdata;
                    if (item.ep_ack)
                    begin
                        cur_address_next = addr_inc;
                    end
                end
            end
            KIND_MODE_WRITE:
            begin
                if (item.xfer_mode != mode_reg)
                begin
                    addr_valid_next        = 1'b0;
                    pf_valid_next          = 1'b0;
                    status_next[READY_BIT] = 1'b0;
                end
                mode_next = item.xfer_mode;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= '0;
            cur_address_reg <= '0;
            addr_valid_reg  <= 1'b0;
            prefetch_reg    <= '0;
            pf_valid_reg    <= 1'b0;
            status_reg      <= '0;
            cfg_index_reg   <= '0;
            idx_valid_reg   <= 1'b0;
        end
        else if (take)
        begin
            mode_reg        <= mode_next;
            cur_address_reg <= cur_address_next;
            addr_valid_reg  <= addr_valid_next;
            prefetch_reg    <= prefetch_next;
            pf_valid_reg    <= pf_valid_next;
            status_reg      <= status_next;
            cfg_index_reg   <= cfg_index_next;
            idx_valid_reg   <= idx_valid_next;
        end
    end

endmodule

@@ hw/rtl/hwb_out_reg.sv @@
// hwb_out_reg: result register of the host window bridge
// depends on hwb_pkg for the result item type
module hwb_out_reg
    import hwb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  res_item_t load_item,
    output logic      valid,
    input  logic      ready,
    output res_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    res_item_t item_reg;

    assign valid_next = load ? 1'b1 : (ready ? 1'b0 : valid_reg);
    assign valid      = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

endmodule

@@ hw/rtl/host_window_bridge_autoinc.sv @@
// host_window_bridge_autoinc: host access window bridging to one endpoint
// depends on hwb_pkg, hwb_in_reg, hwb_core, hwb_out_reg
//
//   channel  direction  handshake                payload
//   host     in         host_valid / host_ready  host_item (host_item_t)
//   res      out        res_valid / res_ready    res_item (res_item_t)
//
// each host transaction yields exactly one result transaction
// accesses pass the input register, then decode into the result register
// one transaction per cycle sustained while res_ready stays high; the only
// loop is the state update in hwb_core, registered when an access is taken
// rst_n clears all bridge state and both valid flags asynchronously
// a stalled result holds the core; an empty input register still takes one more
// transaction, after which host_ready stays low until res_ready returns
module host_window_bridge_autoinc
    import hwb_pkg::*;
#(
    parameter logic [OFFSET_W-1:0] STATUS_OFFSET = STATUS_OFFSET_DEF,
    parameter logic [OFFSET_W-1:0] INDEX_OFFSET  = INDEX_OFFSET_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       host_valid,
    output logic       host_ready,
    input  host_item_t host_item,
    output logic       res_valid,
    input  logic       res_ready,
    output res_item_t  res_item
);

    logic       stage_valid;
    host_item_t stage_item;
    res_item_t  core_result;
    logic       take;

    // the staged access moves on when the result register is empty or draining
    assign take = stage_valid && (!res_valid || res_ready);

    hwb_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (host_valid),
        .ready       (host_ready),
        .item        (host_item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    // decode and state update happen in the same cycle the access is taken
    hwb_core #(
        .STATUS_OFFSET (STATUS_OFFSET),
        .INDEX_OFFSET  (INDEX_OFFSET)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (stage_item),
        .result (core_result)
    );

    hwb_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .load_item (core_result),
        .valid     (res_valid),
        .ready     (res_ready),
        .item      (res_item)
    );

endmodule

@@ tb/sv/hwb_tb_pkg.sv @@
// hwb_tb_pkg: reply predictor and scoreboard for the host window bridge testbench
// depends on hwb_pkg for the payload structs and the access, mode and request codes
package hwb_tb_pkg;

    import hwb_pkg::*;

    class bridge_scoreboard;

        // bridge state as the predictor sees it
        logic [1:0]          mode;
        logic [WORD_W-1:0]   cur_addr;
        logic                addr_valid;
        logic [WORD_W-1:0]   prefetch_word;
        logic                prefetch_valid;
        logic [STATUS_W-1:0] status_word;
        logic [INDEX_W-1:0]  cfg_index;
        logic                index_valid;

        res_item_t pending_replies[$];

        int errors;
        int checked;
        int accepted;
        int prefetch_hits;
        int req_count[8];

        function new();
            mode           = '0;
            cur_addr       = '0;
            addr_valid     = 1'b0;
            prefetch_word  = '0;
            prefetch_valid = 1'b0;
            status_word    = '0;
            cfg_index      = '0;
            index_valid    = 1'b0;
            errors         = 0;
            checked        = 0;
            accepted       = 0;
            prefetch_hits  = 0;
            foreach (req_count[i])
                req_count[i] = 0;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        // work out the reply to one host transaction and update the state
        function void note_access(host_item_t it);
            res_item_t r;
            r = '0;
            accepted++;
            case (it.kind)
                KIND_HOST_READ:
                begin
                    r.rdata = ALL_ONES;
                    if (it.offset == STATUS_OFFSET_DEF)
                        r.rdata = {16'h0, status_word};
                    else if (index_valid)
                    begin
                        r.req_kind  = REQ_CFG_READ;
                        r.req_index = cfg_index;
                        if (it.cfg_ack)
                            r.rdata = {24'h0, it.cfg_rdata};
                        index_valid = 1'b0;
                    end
                    else if (addr_valid && mode == MODE_READ)
                    begin
                        if (prefetch_valid)
                        begin
                            r.rdata        = prefetch_word;
                            prefetch_valid = 1'b0;
                            cur_addr       = cur_addr + ADDR_STEP;
                            prefetch_hits++;
                        end
                        else
                        begin
                            r.req_kind = REQ_READ;
                            r.req_addr = cur_addr;
                            if (it.ep_ack)
                            begin
                                r.rdata  = it.ep_rdata;
                                cur_addr = cur_addr + ADDR_STEP;
                            end
                        end
                    end
                end
                KIND_HOST_WRITE:
                begin
                    if (it.offset == STATUS_OFFSET_DEF)
                    begin
                        status_word            = it.wdata[15:0];
                        status_word[READY_BIT] = 1'b0;
                        addr_valid             = 1'b0;
                        prefetch_valid         = 1'b0;
                        index_valid            = 1'b0;
                    end
                    else if (it.offset == INDEX_OFFSET_DEF)
                    begin
                        cfg_index      = {it.wdata[7], it.wdata[3:0]};
                        index_valid    = (cfg_index != '0);
                        addr_valid     = 1'b0;
                        prefetch_valid = 1'b0;
                    end
                    else if (index_valid)
                    begin
                        r.req_kind  = REQ_CFG_WRITE;
                        r.req_index = cfg_index;
                        r.req_wdata = {24'h0, it.wdata[7:0]};
                        index_valid = 1'b0;
                    end
                    else if (!addr_valid)
                    begin
                        cur_addr       = {8'h0, it.wdata[23:0]};
                        addr_valid     = 1'b1;
                        prefetch_valid = 1'b0;
                        if (mode == MODE_READ)
                        begin
                            r.req_kind = REQ_READ;
                            r.req_addr = cur_addr;
                            if (it.ep_ack)
                            begin
                                prefetch_word          = it.ep_rdata;
                                prefetch_valid         = 1'b1;
                                status_word[READY_BIT] = 1'b1;
                            end
                        end
                    end
                    else if (mode == MODE_WRITE)
                    begin
                        r.req_kind  = REQ_WRITE;
                        r.req_addr  = cur_addr;
                        r.req_wdata = it.wdata;
                        if (it.ep_ack)
                            cur_addr = cur_addr + ADDR_STEP;
                    end
                end
                KIND_MODE_WRITE:
                begin
                    if (it.xfer_mode != mode)
                    begin
                        addr_valid             = 1'b0;
                        prefetch_valid         = 1'b0;
                        status_word[READY_BIT] = 1'b0;
                    end
                    mode = it.xfer_mode;
                end
                default:
                begin
                    // unused kind, reply stays all zero
                end
            endcase
            req_count[r.req_kind]++;
            pending_replies.push_back(r);
        endfunction

        function void check_reply(res_item_t got);
            res_item_t want;
            if (pending_replies.size() == 0)
            begin
                $error("result %h arrived with no reply pending", got);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            checked++;
            if (got.rdata !== want.rdata)
            begin
                $error("rdata mismatch: expected %h, actual %h", want.rdata, got.rdata);
                errors++;
            end
            if (got.req_kind !== want.req_kind)
            begin
                $error("req_kind mismatch: expected %0d, actual %0d",
                       want.req_kind, got.req_kind);
                errors++;
            end
            if (got.req_addr !== want.req_addr)
            begin
                $error("req_addr mismatch: expected %h, actual %h", want.req_addr, got.req_addr);
                errors++;
            end
            if (got.req_index !== want.req_index)
            begin
                $error("req_index mismatch: expected %0d, actual %0d",
                       want.req_index, got.req_index);
                errors++;
            end
            if (got.req_wdata !== want.req_wdata)
            begin
                $error("req_wdata mismatch: expected %h, actual %h",
                       want.req_wdata, got.req_wdata);
                errors++;
            end
        endfunction

    endclass

endpackage

@@ tb/sv/host_window_bridge_autoinc_tb.sv @@
// host_window_bridge_autoinc_tb: drives host accesses into the bridge and checks each result
// depends on hwb_pkg, hwb_tb_pkg and the host_window_bridge_autoinc rtl
// directed corner accesses first, then random read, write and config sessions mixed with noise
module host_window_bridge_autoinc_tb;

    import hwb_pkg::*;
    import hwb_tb_pkg::*;

    localparam int TOTAL_ACCESSES = 920;
    localparam int DRAIN_CYCLES   = 10;
    localparam int IDLE_LIMIT     = 1000;
    localparam int HOLD_START     = 300;
    localparam int HOLD_CYCLES    = 80;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       host_valid;
    logic       host_ready;
    host_item_t host_item;
    logic       res_valid;
    logic       res_ready;
    res_item_t  res_item;

    bridge_scoreboard sb = new();

    // sender burst bookkeeping
    int burst_left = 0;

    host_window_bridge_autoinc dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .host_valid (host_valid),
        .host_ready (host_ready),
        .host_item  (host_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // host access with the endpoint answer fields filled at random
    // acks lean towards success so that addresses keep advancing
    function automatic host_item_t make_access(input logic [1:0] kind,
                                               input logic [OFFSET_W-1:0] offset,
                                               input logic [WORD_W-1:0] wdata);
        host_item_t it;
        it.kind      = kind;
        it.offset    = offset;
        it.wdata     = wdata;
        it.xfer_mode = 2'($urandom_range(0, 3));
        it.ep_ack    = ($urandom_range(0, 7) != 0);
        it.ep_rdata  = $urandom;
        it.cfg_ack   = ($urandom_range(0, 3) != 0);
        it.cfg_rdata = 8'($urandom);
        return it;
    endfunction

    // data offsets span the whole window, the special offsets only by chance
    function automatic logic [OFFSET_W-1:0] data_offset();
        logic [WORD_W-1:0] r;
        r = $urandom;
        return r[OFFSET_W-1:0];
    endfunction

    // one host transaction; called at a rising edge, returns at the accepting edge
    // a new burst may open with a gap, otherwise valid stays high back to back
    task automatic offer(input host_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                host_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        host_item  <= it;
        host_valid <= 1'b1;
        @(posedge clk);
        while (!host_ready)
            @(posedge clk);
        sb.note_access(it);
    endtask

    task automatic access(input logic [1:0] kind, input logic [OFFSET_W-1:0] offset,
                          input logic [WORD_W-1:0] wdata);
        offer(make_access(kind, offset, wdata));
    endtask

    task automatic set_mode(input logic [1:0] m);
        host_item_t it;
        it           = make_access(KIND_MODE_WRITE, data_offset(), $urandom);
        it.xfer_mode = m;
        offer(it);
    endtask

    // corner cases walked one by one from reset
    task automatic directed_accesses();
        host_item_t it;
        // status after reset, read with nothing latched, unused kind with every bit set
        access(KIND_HOST_READ, STATUS_OFFSET_DEF, '0);
        access(KIND_HOST_READ, 24'h00_0010, '0);
        it = '1;
        offer(it);
        // read mode: address latch with prefetch, ready bit, prefetch hit
        set_mode(MODE_READ);
        it = make_access(KIND_HOST_WRITE, 24'hFF_FFFF, '1);
        it.ep_ack = 1'b1;
        offer(it);
        access(KIND_HOST_READ, STATUS_OFFSET_DEF, '0);
        access(KIND_HOST_READ, 24'h00_0000, '0);
        // data read refused, then accepted with a zero word
        it = make_access(KIND_HOST_READ, 24'h00_0004, '0);
        it.ep_ack = 1'b0;
        offer(it);
        it = make_access(KIND_HOST_READ, 24'h00_0004, '0);
        it.ep_ack   = 1'b1;
        it.ep_rdata = '0;
        offer(it);
        // same mode again leaves everything alone
        set_mode(MODE_READ);
        // status write drops the ready bit and the address phase
        access(KIND_HOST_WRITE, STATUS_OFFSET_DEF, '1);
        // index from bit 7 alone, config read refused
        access(KIND_HOST_WRITE, INDEX_OFFSET_DEF, 32'h0000_0080);
        it = make_access(KIND_HOST_READ, 24'h12_3456, '0);
        it.cfg_ack = 1'b0;
        offer(it);
        // largest index, config read answered with all ones
        access(KIND_HOST_WRITE, INDEX_OFFSET_DEF, 32'hFFFF_FF8F);
        it = make_access(KIND_HOST_READ, 24'h00_0000, '0);
        it.cfg_ack   = 1'b1;
        it.cfg_rdata = 8'hFF;
        offer(it);
        // zero index arms no config access; an index from bits 3:0 alone arms a config write
        access(KIND_HOST_WRITE, INDEX_OFFSET_DEF, 32'h0000_0070);
        access(KIND_HOST_WRITE, INDEX_OFFSET_DEF, 32'h0000_000F);
        access(KIND_HOST_WRITE, 24'hFF_FFFF, '1);
        // write mode: zero address, refused write, accepted write
        set_mode(MODE_WRITE);
        access(KIND_HOST_WRITE, 24'h00_0100, '0);
        it = make_access(KIND_HOST_WRITE, 24'h00_0100, 32'hA5A5_5A5A);
        it.ep_ack = 1'b0;
        offer(it);
        it = make_access(KIND_HOST_WRITE, 24'h00_0100, '1);
        it.ep_ack = 1'b1;
        offer(it);
        // other mode: latch without request, then data write ignored
        set_mode(MODE_OTHER);
        access(KIND_HOST_WRITE, 24'h00_0200, 32'h00AB_CDEF);
        access(KIND_HOST_WRITE, 24'h00_0200, 32'h1234_5678);
        // prefetch refused, the following read goes to the endpoint
        set_mode(MODE_READ);
        it = make_access(KIND_HOST_WRITE, 24'h00_0300, 32'h0000_1000);
        it.ep_ack = 1'b0;
        offer(it);
        it = make_access(KIND_HOST_READ, 24'h00_0300, '0);
        it.ep_ack = 1'b1;
        offer(it);
        // unnamed mode value is stored as given
        set_mode(2'd3);
    endtask

    task automatic read_session();
        int n;
        int pick;
        set_mode(MODE_READ);
        access(KIND_HOST_WRITE, data_offset(), $urandom);
        n = $urandom_range(1, 12);
        repeat (n)
        begin
            pick = $urandom_range(0, 11);
            if (pick == 0)
                access(KIND_HOST_READ, STATUS_OFFSET_DEF, $urandom);
            else if (pick == 1)
                access(KIND_HOST_WRITE, data_offset(), $urandom);
            else
                access(KIND_HOST_READ, data_offset(), $urandom);
        end
    endtask

    task automatic write_session();
        int n;
        int pick;
        set_mode(MODE_WRITE);
        access(KIND_HOST_WRITE, data_offset(), $urandom);
        n = $urandom_range(1, 12);
        repeat (n)
        begin
            pick = $urandom_range(0, 11);
            if (pick == 0)
                access(KIND_HOST_READ, data_offset(), $urandom);
            else if (pick == 1)
                access(KIND_HOST_READ, STATUS_OFFSET_DEF, $urandom);
            else
                access(KIND_HOST_WRITE, data_offset(), $urandom);
        end
    endtask

    // index write, then one or two accesses that may turn into config requests
    task automatic cfg_session();
        int n;
        access(KIND_HOST_WRITE, INDEX_OFFSET_DEF, $urandom);
        n = $urandom_range(1, 2);
        repeat (n)
            access(2'($urandom_range(0, 1)), data_offset(), $urandom);
    endtask

    task automatic noise(input int n);
        host_item_t it;
        repeat (n)
        begin
            it          = make_access(2'($urandom_range(0, 3)), data_offset(), $urandom);
            it.ep_ack   = 1'($urandom_range(0, 1));
            it.cfg_ack  = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
                it.offset = ($urandom_range(0, 1) != 0) ? STATUS_OFFSET_DEF : INDEX_OFFSET_DEF;
            offer(it);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        int pick;
        rst_n      <= 1'b0;
        host_valid <= 1'b0;
        host_item  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_accesses();

        while (sb.accepted < TOTAL_ACCESSES)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 2)
                read_session();
            else if (pick <= 5)
                write_session();
            else if (pick <= 7)
                cfg_session();
            else if (pick == 8)
            begin
                access(KIND_HOST_WRITE, STATUS_OFFSET_DEF, $urandom);
                access(KIND_HOST_READ, STATUS_OFFSET_DEF, $urandom);
            end
            else
                noise($urandom_range(1, 3));
        end
        host_valid <= 1'b0;

        // wait for every reply, then let the pipeline settle
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d host transactions, %0d results checked, %0d prefetch hits",
                 sb.accepted, sb.checked, sb.prefetch_hits);
        $display("endpoint requests: read %0d, write %0d, cfg read %0d, cfg write %0d",
                 sb.req_count[REQ_READ], sb.req_count[REQ_WRITE],
                 sb.req_count[REQ_CFG_READ], sb.req_count[REQ_CFG_WRITE]);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result side: check at the edge, then choose ready for the next cycle
    // the pattern rotates through always ready, coin flips, a fixed one in five
    // stall and mostly ready; one long hold-off lets the bridge fill and stall input
    initial
    begin
        int cyc;
        int hold_left;
        logic take;
        cyc       = 0;
        hold_left = 0;
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
                sb.check_reply(res_item);
            cyc++;
            if (cyc == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else
            begin
                case ((cyc / 97) % 4)
                    0: take = 1'b1;
                    1: take = 1'($urandom_range(0, 1));
                    2: take = ((cyc % 5) != 0);
                    default: take = ($urandom_range(0, 7) != 0);
                endcase
            end
            res_ready <= take;
        end
    end

    // watchdog: too long without any transaction on either channel ends the run
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((host_valid && host_ready) || (res_valid && res_ready))
                idle = 0;
            else
                idle++;
        end
        $display("no transaction for %0d cycles, %0d replies still pending",
                 IDLE_LIMIT, sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
